// File: design/mau_pkg.sv
`default_nettype none

package mau_pkg;

	localparam int ACTION_W = 3;
	localparam int EXP_W = 64;
	localparam int EXP_IDX_W = 6;
	localparam logic [EXP_W-1:0] RESET_MODULUS = 64'd998244353;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD = 3'd0,
		ACT_SUB = 3'd1,
		ACT_MUL = 3'd2,
		ACT_DIV = 3'd3,
		ACT_POW = 3'd4,
		ACT_INV = 3'd5
	} action_t;

	typedef enum logic {
		OP_MULMOD = 1'b0,
		OP_ADDMOD = 1'b1
	} mau_op_t;

	typedef struct packed {
		logic    start;
		mau_op_t op;
	} mau_req_t;

endpackage

`default_nettype wire

// File: design/mau_mulmod.sv
`default_nettype none

module mau_mulmod
	import mau_pkg::*;
#(
	parameter int MOD_WIDTH = 30
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mau_req_t             req,
	input  wire logic [MOD_WIDTH-1:0] x,
	input  wire logic [MOD_WIDTH-1:0] y,
	input  wire logic [MOD_WIDTH-1:0] m,
	output logic                      done,
	output logic [MOD_WIDTH-1:0]      p
);

	localparam int CNT_W = $clog2(MOD_WIDTH + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 dbl_q;
	logic [MOD_WIDTH-1:0] x_q;
	logic [MOD_WIDTH-1:0] y_q;
	logic [MOD_WIDTH-1:0] p_q;

	logic [MOD_WIDTH:0]   m_ext;
	logic [MOD_WIDTH:0]   t;
	logic [MOD_WIDTH:0]   t_red;
	logic [MOD_WIDTH:0]   u;
	logic [MOD_WIDTH:0]   u_red;
	logic [MOD_WIDTH-1:0] p_nxt;

	// one bit of the interleaved product: double (multiply only), reduce, add, reduce
	always_comb begin
		m_ext = {1'b0, m};
		t     = dbl_q ? {p_q, 1'b0} : {1'b0, p_q};
		t_red = (t >= m_ext) ? t - m_ext : t;
		u     = {1'b0, t_red[MOD_WIDTH-1:0]} + {1'b0, x_q};
		u_red = (u >= m_ext) ? u - m_ext : u;
		p_nxt = y_q[MOD_WIDTH-1] ? u_red[MOD_WIDTH-1:0] : t_red[MOD_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				case (req.op)
					OP_ADDMOD: cnt_q <= CNT_W'(1);
					default:   cnt_q <= CNT_W'(MOD_WIDTH);
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= x;
			case (req.op)
				OP_ADDMOD: begin
					dbl_q <= 1'b0;
					p_q   <= y;
					y_q   <= {1'b1, {(MOD_WIDTH-1){1'b0}}};
				end
				default: begin
					dbl_q <= 1'b1;
					p_q   <= '0;
					y_q   <= y;
				end
			endcase
		end else if (busy_q) begin
			p_q <= p_nxt;
			y_q <= {y_q[MOD_WIDTH-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign p    = p_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("mulmod started while busy");

	a_done_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q)
		else $error("mulmod finished without done");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("mulmod done longer than one cycle");

endmodule

`default_nettype wire

// File: design/modular_arithmetic_unit.sv
`default_nettype none

// channel   direction  handshake               payload
// in        to block   in_valid / in_stall     action, operand_a, operand_b, exponent
// out       from block out_valid / out_stall   result
// cfg       to block   cfg_we                  cfg_wdata (modulus)
//
// every modular multiply runs on the shared bit-serial add/compare unit
// add, subtract, multiply: both operands are first reduced on the unit, then one add or multiply
// inverse: up to 2*MOD_WIDTH more multiplies, divide one more; power: up to 128, +2*MOD_WIDTH if negative
// a modulus below two gives 0 without using the multiply unit; in_stall is high until hand-off
// the output register holds a result under out_stall while the next transaction is taken
// arst_n clears control state and loads the default modulus

module modular_arithmetic_unit
	import mau_pkg::*;
#(
	parameter int MOD_WIDTH = 30
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [MOD_WIDTH-1:0] cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [ACTION_W-1:0]  action,
	input  wire logic [MOD_WIDTH-1:0] operand_a,
	input  wire logic [MOD_WIDTH-1:0] operand_b,
	input  wire logic signed [EXP_W-1:0] exponent,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [MOD_WIDTH-1:0]      result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_A,
		ST_RED_B,
		ST_ARITH,
		ST_POW_SQ,
		ST_POW_MUL,
		ST_FINISH
	} state_t;

	localparam logic [MOD_WIDTH-1:0] ONE = MOD_WIDTH'(1);
	localparam logic [EXP_IDX_W-1:0] TOP_BIT_INV = EXP_IDX_W'(MOD_WIDTH - 1);
	localparam logic [EXP_IDX_W-1:0] TOP_BIT_POW = EXP_IDX_W'(EXP_W - 1);

	state_t               state_q;
	logic [MOD_WIDTH-1:0] modulus_q;
	logic [ACTION_W-1:0]  act_q;
	logic [MOD_WIDTH-1:0] a_q;
	logic [MOD_WIDTH-1:0] b_q;
	logic [EXP_W-1:0]     exp_q;
	logic [EXP_IDX_W-1:0] bit_q;
	logic [MOD_WIDTH-1:0] acc_q;
	logic [MOD_WIDTH-1:0] base_q;
	logic                 neg_q;
	logic                 inv_pass_q;
	mau_req_t             req_q;
	logic [MOD_WIDTH-1:0] eng_x_q;
	logic [MOD_WIDTH-1:0] eng_y_q;
	logic                 out_valid_q;
	logic [MOD_WIDTH-1:0] result_q;

	logic                 eng_done;
	logic [MOD_WIDTH-1:0] eng_p;
	logic                 in_acc;
	logic                 m_small;
	logic [MOD_WIDTH-1:0] neg_b;
	logic [EXP_W-1:0]     inv_exp;
	logic [EXP_W-1:0]     exp_u;
	logic [EXP_W-1:0]     exp_abs;

	mau_mulmod #(
		.MOD_WIDTH(MOD_WIDTH)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_q),
		.x     (eng_x_q),
		.y     (eng_y_q),
		.m     (modulus_q),
		.done  (eng_done),
		.p     (eng_p)
	);

	always_comb begin
		in_acc  = in_valid && (state_q == ST_IDLE);
		m_small = modulus_q < MOD_WIDTH'(2);
		neg_b   = (eng_p == '0) ? '0 : modulus_q - eng_p;
		inv_exp = {{(EXP_W-MOD_WIDTH){1'b0}}, modulus_q - MOD_WIDTH'(2)};
		exp_u   = $unsigned(exponent);
		exp_abs = exp_u[EXP_W-1] ? (~exp_u + EXP_W'(1)) : exp_u;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			modulus_q   <= RESET_MODULUS[MOD_WIDTH-1:0];
			req_q       <= '{start: 1'b0, op: OP_MULMOD};
			out_valid_q <= 1'b0;
			inv_pass_q  <= 1'b0;
		end else begin
			req_q.start <= 1'b0;
			if (cfg_we) begin
				modulus_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						act_q      <= action;
						b_q        <= operand_b;
						neg_q      <= exp_u[EXP_W-1];
						exp_q      <= exp_abs;
						inv_pass_q <= 1'b0;
						if (m_small) begin
							acc_q   <= '0;
							state_q <= ST_FINISH;
						end else begin
							req_q   <= '{start: 1'b1, op: OP_MULMOD};
							eng_x_q <= ONE;
							eng_y_q <= operand_a;
							state_q <= ST_RED_A;
						end
					end
				end
				ST_RED_A: begin
					if (eng_done) begin
						a_q     <= eng_p;
						req_q   <= '{start: 1'b1, op: OP_MULMOD};
						eng_x_q <= ONE;
						eng_y_q <= b_q;
						state_q <= ST_RED_B;
					end
				end
				ST_RED_B: begin
					if (eng_done) begin
						case (act_q)
							ACT_ADD: begin
								req_q   <= '{start: 1'b1, op: OP_ADDMOD};
								eng_x_q <= eng_p;
								eng_y_q <= a_q;
								state_q <= ST_ARITH;
							end
							ACT_SUB: begin
								req_q   <= '{start: 1'b1, op: OP_ADDMOD};
								eng_x_q <= neg_b;
								eng_y_q <= a_q;
								state_q <= ST_ARITH;
							end
							ACT_MUL: begin
								req_q   <= '{start: 1'b1, op: OP_MULMOD};
								eng_x_q <= a_q;
								eng_y_q <= eng_p;
								state_q <= ST_ARITH;
							end
							ACT_DIV: begin
								base_q  <= eng_p;
								exp_q   <= inv_exp;
								bit_q   <= TOP_BIT_INV;
								acc_q   <= ONE;
								req_q   <= '{start: 1'b1, op: OP_MULMOD};
								eng_x_q <= ONE;
								eng_y_q <= ONE;
								state_q <= ST_POW_SQ;
							end
							ACT_POW: begin
								base_q  <= a_q;
								bit_q   <= TOP_BIT_POW;
								acc_q   <= ONE;
								req_q   <= '{start: 1'b1, op: OP_MULMOD};
								eng_x_q <= ONE;
								eng_y_q <= ONE;
								state_q <= ST_POW_SQ;
							end
							ACT_INV: begin
								base_q  <= a_q;
								exp_q   <= inv_exp;
								bit_q   <= TOP_BIT_INV;
								acc_q   <= ONE;
								req_q   <= '{start: 1'b1, op: OP_MULMOD};
								eng_x_q <= ONE;
								eng_y_q <= ONE;
								state_q <= ST_POW_SQ;
							end
							default: begin
								acc_q   <= '0;
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_ARITH: begin
					if (eng_done) begin
						acc_q   <= eng_p;
						state_q <= ST_FINISH;
					end
				end
				ST_POW_SQ, ST_POW_MUL: begin
					if (eng_done) begin
						acc_q <= eng_p;
						if (state_q == ST_POW_SQ && exp_q[bit_q]) begin
							req_q   <= '{start: 1'b1, op: OP_MULMOD};
							eng_x_q <= base_q;
							eng_y_q <= eng_p;
							state_q <= ST_POW_MUL;
						end else if (bit_q != '0) begin
							bit_q   <= bit_q - EXP_IDX_W'(1);
							req_q   <= '{start: 1'b1, op: OP_MULMOD};
							eng_x_q <= eng_p;
							eng_y_q <= eng_p;
							state_q <= ST_POW_SQ;
						end else begin
							case (act_q)
								ACT_DIV: begin
									req_q   <= '{start: 1'b1, op: OP_MULMOD};
									eng_x_q <= a_q;
									eng_y_q <= eng_p;
									state_q <= ST_ARITH;
								end
								ACT_POW: begin
									if (neg_q && !inv_pass_q) begin
										inv_pass_q <= 1'b1;
										base_q     <= eng_p;
										exp_q      <= inv_exp;
										bit_q      <= TOP_BIT_INV;
										acc_q      <= ONE;
										req_q      <= '{start: 1'b1, op: OP_MULMOD};
										eng_x_q    <= ONE;
										eng_y_q    <= ONE;
										state_q    <= ST_POW_SQ;
									end else begin
										state_q <= ST_FINISH;
									end
								end
								default: begin
									state_q <= ST_FINISH;
								end
							endcase
						end
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						result_q    <= acc_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q != ST_IDLE)
		else $error("transaction accepted but sequencer stayed idle");

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		eng_done |-> state_q != ST_IDLE && state_q != ST_FINISH)
		else $error("mulmod result arrived with nobody waiting");

	a_finish_hands_off: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && (!out_valid_q || !out_stall)
			|=> out_valid && state_q == ST_IDLE)
		else $error("finished result not moved to output register");

endmodule

`default_nettype wire
